// ----- hw/rtl/hex_field_formatter_top_macros.svh -----
// Assertion macros used by the hex field formatter checker.
`ifndef HEX_FIELD_FORMATTER_TOP_MACROS_SVH
`define HEX_FIELD_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define HFF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hff check failed: same-cycle implication");

// Next-cycle implication, sampled on clock, off while reset is high.
`define HFF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hff check failed: next-cycle implication");

`endif

// ----- hw/rtl/hff_pkg.sv -----
// Shared types, constants and microcode program of the hex field formatter.
package hff_pkg;

   localparam int DEF_VALUE_BITS = 64;
   localparam int DEF_MAX_FIELD  = 60;
   localparam int LEN_W          = 6;
   localparam int STEP_W         = 4;
   localparam int REQ_DATA_W     = 88;
   localparam int RSP_DATA_W     = 16;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_LX    = 8'h78;
   localparam logic [7:0] ASCII_UX    = 8'h58;
   localparam logic [7:0] ASCII_LA    = 8'h61;
   localparam logic [7:0] ASCII_UA    = 8'h41;

   typedef enum logic [2:0] {
      OP_WAIT, OP_DIGITS, OP_BODY, OP_PAD, OP_EMIT, OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      CH_SPACE, CH_ZERO, CH_X, CH_DIGIT
   } char_sel_type;

   typedef enum logic [1:0] {
      CNT_ONE, CNT_SPACES, CNT_NZEROS, CNT_NDIG
   } cnt_sel_type;

   typedef enum logic [2:0] {
      C_ALWAYS, C_LEAD, C_PREFIX, C_ZFILL, C_TRAIL
   } cond_type;

   typedef struct packed {
      op_type              op;
      char_sel_type        char_sel;
      cnt_sel_type         cnt_sel;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_word_type;

   typedef struct packed {
      logic              req_valid;
      logic              cond_ok;
      logic              slot_free;
      logic [LEN_W-1:0]  run_len;
   } seq_status_type;

   typedef struct packed {
      ucode_word_type    word;
      logic              accept;
      logic              fire;
      logic [LEN_W-1:0]  run_cnt;
   } seq_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;

   // Program: wait, three setup steps, seven character runs, return.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{op: OP_DONE, char_sel: CH_SPACE, cnt_sel: CNT_ONE, cond: C_ALWAYS,
            target: STEP_IDLE};
      unique case (step)
         4'd0:  w.op = OP_WAIT;
         4'd1:  w.op = OP_DIGITS;
         4'd2:  w.op = OP_BODY;
         4'd3:  w.op = OP_PAD;
         4'd4:  w = '{OP_EMIT, CH_SPACE, CNT_SPACES, C_LEAD,   STEP_IDLE};
         4'd5:  w = '{OP_EMIT, CH_ZERO,  CNT_ONE,    C_PREFIX, STEP_IDLE};
         4'd6:  w = '{OP_EMIT, CH_X,     CNT_ONE,    C_PREFIX, STEP_IDLE};
         4'd7:  w = '{OP_EMIT, CH_ZERO,  CNT_SPACES, C_ZFILL,  STEP_IDLE};
         4'd8:  w = '{OP_EMIT, CH_ZERO,  CNT_NZEROS, C_ALWAYS, STEP_IDLE};
         4'd9:  w = '{OP_EMIT, CH_DIGIT, CNT_NDIG,   C_ALWAYS, STEP_IDLE};
         4'd10: w = '{OP_EMIT, CH_SPACE, CNT_SPACES, C_TRAIL,  STEP_IDLE};
         default: w.op = OP_DONE;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? ASCII_UA : ASCII_LA;
      if (nib < 4'd10) begin
         return ASCII_ZERO + {4'd0, nib};
      end
      return base + {4'd0, nib - 4'd10};
   endfunction

endpackage

// ----- hw/rtl/hex_field_formatter_top.sv -----
// Hex field formatter: printf-style %x field builder streaming one character per transfer.
//
// Usage
//   Request channel (req_*): one transfer carries a value and its conversion flags
//   (width, precision, left align, zero pad, alternate 0x prefix, letter case).
//   Response channel (rsp_*): the formatted field, one ASCII character per transfer,
//   field length on every transfer and tlast on the final character. A field that
//   comes out empty (zero value, precision zero, width zero) yields no transfers.
//   Width and precision above MAX_FIELD saturate to it; a negative precision is absent.
// Sequencing
//   Items are handled one at a time by a microcoded sequencer. After the request
//   transfer, three setup steps size the field, then seven character runs follow,
//   one character per cycle while the response register has room; a run whose
//   condition fails or whose length is zero is skipped. The next request is taken
//   only after the last run and the return step. Each character is registered in the
//   response register. The digit run reads one nibble per cycle through a mux, also
//   only while the response register has room.
// Reset and stalls
//   Reset returns the sequencer to its wait step and empties the response register.
//   While the response register is full and rsp_tready is low, a character run holds;
//   the next request can be taken before the last character has been taken.
module hex_field_formatter_top
   import hff_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int MAX_FIELD  = DEF_MAX_FIELD
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // value [63:0], upper_case [64], field_width [70:65], precision [77:71],
   // left_align [78], zero_pad [79], alt_prefix [80], zero [87:81]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // character [7:0], field_length [13:8], zero [15:14]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int NIBBLES = (VALUE_BITS + 3) / 4;
   localparam int VAL_PAD = NIBBLES * 4;
   localparam int NIB_IW  = $clog2(NIBBLES);
   localparam int DIG_W   = $clog2(NIBBLES + 1);

   // unpack the request transfer
   logic [VALUE_BITS-1:0] req_value;
   logic                  req_upper;
   logic [LEN_W-1:0]      req_width;
   logic [6:0]            req_prec;
   logic                  req_left;
   logic                  req_zpad;
   logic                  req_alt;

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign req_upper = req_tdata[64];
   assign req_width = req_tdata[70:65];
   assign req_prec  = req_tdata[77:71];
   assign req_left  = req_tdata[78];
   assign req_zpad  = req_tdata[79];
   assign req_alt   = req_tdata[80];

   seq_status_type status;
   seq_ctrl_type   ctrl;

   hff_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // datapath registers
   logic [VAL_PAD-1:0] value_ff, value_in;
   logic               upper_ff, upper_in;
   logic               left_ff, left_in;
   logic               zpad_ff, zpad_in;
   logic               alt_ff, alt_in;
   logic               has_prec_ff, has_prec_in;
   logic [LEN_W-1:0]   width_ff, width_in;
   logic [LEN_W-1:0]   prec_ff, prec_in;
   logic [DIG_W-1:0]   ndig_ff, ndig_in;
   logic               prefix_ff, prefix_in;
   logic [LEN_W-1:0]   nzeros_ff, nzeros_in;
   logic [LEN_W-1:0]   spaces_ff, spaces_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   out_cnt_ff, out_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [DIG_W-1:0]   ndig_calc;
   logic               value_zero;
   logic [LEN_W-1:0]   ndig_ext;
   logic [LEN_W-1:0]   body_len;
   logic [LEN_W-1:0]   digit_pos;
   logic [NIB_IW-1:0]  nib_idx;
   logic [3:0]         nibble;
   logic [7:0]         emit_char;

   assign value_zero = ~|value_ff;
   assign ndig_ext   = LEN_W'(ndig_ff);

   // highest nonzero nibble sets the digit count; at least one digit, none for a zero value with precision zero
   always_comb begin
      ndig_calc = DIG_W'(1);
      for (int i = 1; i < NIBBLES; i++) begin
         if (|value_ff[i*4 +: 4]) begin
            ndig_calc = DIG_W'(i + 1);
         end
      end
      if (has_prec_ff && prec_ff == '0 && value_zero) begin
         ndig_calc = '0;
      end
   end

   // digits plus precision zeros
   assign body_len = (has_prec_ff && prec_ff > ndig_ext) ? prec_ff : ndig_ext;

   // status back to the sequencer
   always_comb begin
      status.req_valid = req_tvalid;
      status.slot_free = !rsp_valid_ff || rsp_tready;
      case (ctrl.word.cnt_sel)
         CNT_ONE:    status.run_len = LEN_W'(1);
         CNT_SPACES: status.run_len = spaces_ff;
         CNT_NZEROS: status.run_len = nzeros_ff;
         default:    status.run_len = ndig_ext;
      endcase
      case (ctrl.word.cond)
         C_ALWAYS: status.cond_ok = 1'b1;
         C_LEAD:   status.cond_ok = !left_ff && !(zpad_ff && !has_prec_ff);
         C_PREFIX: status.cond_ok = prefix_ff;
         C_ZFILL:  status.cond_ok = !left_ff && zpad_ff && !has_prec_ff;
         C_TRAIL:  status.cond_ok = left_ff;
         default:  status.cond_ok = 1'b0;
      endcase
   end

   assign req_tready = (ctrl.word.op == OP_WAIT);

   // digits go out most significant first
   assign digit_pos = ndig_ext - LEN_W'(1) - ctrl.run_cnt;
   assign nib_idx   = digit_pos[NIB_IW-1:0];
   assign nibble    = value_ff[nib_idx*4 +: 4];

   always_comb begin
      case (ctrl.word.char_sel)
         CH_SPACE: emit_char = ASCII_SPACE;
         CH_ZERO:  emit_char = ASCII_ZERO;
         CH_X:     emit_char = upper_ff ? ASCII_UX : ASCII_LX;
         default:  emit_char = hex_char(nibble, upper_ff);
      endcase
   end

   // next values of the datapath
   always_comb begin
      value_in    = value_ff;
      upper_in    = upper_ff;
      left_in     = left_ff;
      zpad_in     = zpad_ff;
      alt_in      = alt_ff;
      has_prec_in = has_prec_ff;
      width_in    = width_ff;
      prec_in     = prec_ff;
      ndig_in     = ndig_ff;
      prefix_in   = prefix_ff;
      nzeros_in   = nzeros_ff;
      spaces_in   = spaces_ff;
      len_in      = len_ff;
      out_cnt_in  = out_cnt_ff;
      case (ctrl.word.op)
         OP_WAIT: begin
            if (ctrl.accept) begin
               value_in    = VAL_PAD'(req_value);
               upper_in    = req_upper;
               left_in     = req_left;
               zpad_in     = req_zpad;
               alt_in      = req_alt;
               has_prec_in = !req_prec[6];
               width_in    = (req_width > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : req_width;
               prec_in     = (req_prec[6]) ? '0 :
                             ((req_prec[5:0] > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD)
                                                                  : req_prec[5:0]);
               out_cnt_in  = '0;
            end
         end
         OP_DIGITS: begin
            ndig_in = ndig_calc;
         end
         OP_BODY: begin
            prefix_in = alt_ff && !value_zero;
            nzeros_in = body_len - ndig_ext;
            len_in    = body_len + ((alt_ff && !value_zero) ? LEN_W'(2) : LEN_W'(0));
         end
         OP_PAD: begin
            spaces_in = (width_ff > len_ff) ? width_ff - len_ff : '0;
            len_in    = (width_ff > len_ff) ? width_ff : len_ff;
         end
         default: begin
            if (ctrl.fire) begin
               out_cnt_in = out_cnt_ff + LEN_W'(1);
            end
         end
      endcase
   end

   // response register: load on fire, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_len_in   = len_ff;
         rsp_last_in  = (out_cnt_ff + LEN_W'(1) == len_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      upper_ff    <= upper_in;
      left_ff     <= left_in;
      zpad_ff     <= zpad_in;
      alt_ff      <= alt_in;
      has_prec_ff <= has_prec_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      ndig_ff     <= ndig_in;
      prefix_ff   <= prefix_in;
      nzeros_ff   <= nzeros_in;
      spaces_ff   <= spaces_in;
      len_ff      <= len_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/hff_sequencer.sv -----
// Microcode sequencer: step counter, program table and run counter.
module hff_sequencer
   import hff_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output seq_ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0]  run_cnt_ff, run_cnt_in;
   ucode_word_type    word;
   logic              accept;
   logic              fire;

   assign word = ucode_rom(step_ff);

   always_comb begin
      step_in    = step_ff;
      run_cnt_in = run_cnt_ff;
      accept     = 1'b0;
      fire       = 1'b0;
      unique case (word.op)
         OP_WAIT: begin
            accept = status.req_valid;
            if (status.req_valid) begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         OP_DIGITS, OP_BODY, OP_PAD: begin
            step_in = step_ff + STEP_W'(1);
         end
         OP_EMIT: begin
            // skip a run whose condition fails or whose length is zero
            if (!status.cond_ok || run_cnt_ff == status.run_len) begin
               step_in    = step_ff + STEP_W'(1);
               run_cnt_in = '0;
            end else if (status.slot_free) begin
               fire = 1'b1;
               if (run_cnt_ff + LEN_W'(1) == status.run_len) begin
                  step_in    = step_ff + STEP_W'(1);
                  run_cnt_in = '0;
               end else begin
                  run_cnt_in = run_cnt_ff + LEN_W'(1);
               end
            end
         end
         OP_DONE: begin
            step_in    = word.target;
            run_cnt_in = '0;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_IDLE;
         run_cnt_ff <= '0;
      end else begin
         step_ff    <= step_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   assign ctrl = '{word: word, accept: accept, fire: fire, run_cnt: run_cnt_ff};

endmodule

// ----- hw/rtl/hff_checker.sv -----
// Port-level checker for the hex field formatter, bound to the top level.
`include "hex_field_formatter_top_macros.svh"

module hff_checker
   import hff_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic             rsp_xfer;
   logic             mid_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] cnt_ff;
   logic             req_seen;

   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign req_seen = req_tvalid && req_tready;

   // track the field in progress from the transfers seen
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (rsp_xfer) begin
         mid_ff <= !rsp_tlast;
         cnt_ff <= rsp_tlast ? '0 : cnt_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         len_ff <= rsp_tdata[13:8];
      end
   end

   `HFF_ASSERT_IMPLY(a_len_steady, rsp_tvalid && mid_ff, rsp_tdata[13:8] == len_ff)
   `HFF_ASSERT_IMPLY(a_last_count, rsp_xfer && rsp_tlast, cnt_ff + LEN_W'(1) == rsp_tdata[13:8])
   `HFF_ASSERT_IMPLY(a_no_empty, rsp_tvalid, rsp_tdata[13:8] != '0 && rsp_tdata[15:14] == 2'b00)
   `HFF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `HFF_ASSERT_NEXT(a_one_at_a_time, req_seen, !req_tready)

endmodule

bind hex_field_formatter_top hff_checker u_hff_checker (.*);
